### rtl/ifsc_pkg.sv
// ----------------------------------------------------------------------------
// ifsc_pkg: shared types and constants of the IMU frame sync parser
// Holds the frame layout constants, the result record and the decoder for
// the known payload kinds.
// ----------------------------------------------------------------------------
package ifsc_pkg;

    // Frame layout: header, type, eight payload bytes and a checksum byte.
    localparam int FRAME_LEN = 11;
    // Bytes held in the cell chain; the last frame byte is the incoming one.
    localparam int HIST_LEN = FRAME_LEN - 1;
    localparam int FILL_W = $clog2(FRAME_LEN);

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] KNOWN_LO = 8'h50;
    localparam logic [7:0] KNOWN_HI = 8'h5A;

    typedef logic [FILL_W-1:0] fill_t;

    // One parsed frame as it leaves the block.
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic        known_type;
    } ifsc_result_t;

    // A type is decoded when it lies in the known range, apart from the header value.
    function automatic logic type_is_known(input logic [7:0] t);
        return (t >= KNOWN_LO) && (t <= KNOWN_HI) && (t != HEADER_BYTE);
    endfunction

endpackage

### rtl/ifsc_cell.sv
// ----------------------------------------------------------------------------
// ifsc_cell: one byte stage of the frame window
// Holds one received byte, takes its neighbor's byte on every accepted
// transaction and adds its own byte into the running checksum.
// ----------------------------------------------------------------------------
module ifsc_cell
    import ifsc_pkg::*;
(
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] sum_in,
    output logic [7:0] byte_out,
    output logic [7:0] sum_out
);

    logic [7:0] byte_reg;

    // The byte moves one place toward the oldest end on each shift.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    // The checksum is modulo 256, so the carry out is dropped.
    assign sum_out  = sum_in + byte_reg;
    assign byte_out = byte_reg;

endmodule

### rtl/imu_frame_sync_checksum_parser_top.sv
// ----------------------------------------------------------------------------
// imu_frame_sync_checksum_parser_top: header sync frame parser with checksum
// Finds 11-byte frames in a received byte stream and emits their fields.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one received byte per transaction on s_rx_byte.
//   The block keeps the last ten bytes in a chain of byte cells. When the
//   eleventh byte of a window arrives, byte 0 must be 0x55 and the low eight
//   bits of the sum of bytes 0 to 9 must equal the incoming byte. A match
//   yields one transaction on the m_ channel (type, four little-endian words
//   and the known-type flag) and empties the window; a mismatch drops the
//   oldest byte and the search goes on with the next byte.
//   A result is registered before it shows on m_valid.
//   Throughput: one byte per cycle while s_ready is high; the checksum is a
//   single pass through the adder chain of the ten cells.
//   A result waiting on a stalled receiver sits in the output register;
//   one more result fits in a skid register, and only when that is full
//   does s_ready drop. Reset (aresetn low, synchronous) empties the window
//   and both result registers; no clearing pass follows.
// ----------------------------------------------------------------------------
module imu_frame_sync_checksum_parser_top
    import ifsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_word_a,
    output logic [15:0] m_word_b,
    output logic [15:0] m_word_c,
    output logic [15:0] m_word_d,
    output logic        m_known_type
);

    logic               s_accept;
    logic [7:0]         tap   [HIST_LEN];
    logic [7:0]         psum  [HIST_LEN+1];
    logic [7:0]         chain [1:HIST_LEN];
    fill_t              fill_reg, fill_next;
    logic               frame_ok;
    ifsc_result_t       result;
    ifsc_result_t       out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    // Newest byte enters at the top cell; cell 0 holds the oldest byte.
    assign chain[HIST_LEN] = s_rx_byte;
    assign psum[0] = 8'h00;

    genvar k;
    generate
        for (k = 0; k < HIST_LEN; k++) begin : g_cell
            ifsc_cell u_cell (
                .aclk     (aclk),
                .shift_en (s_accept),
                .byte_in  (chain[k+1]),
                .sum_in   (psum[k]),
                .byte_out (tap[k]),
                .sum_out  (psum[k+1])
            );
            // Every cell but the oldest feeds the cell below it.
            if (k > 0) begin : g_link
                assign chain[k] = tap[k];
            end
        end
    endgenerate

    // A frame is complete when ten bytes are held and the incoming one closes it.
    assign frame_ok = s_accept && (fill_reg == fill_t'(HIST_LEN))
                      && (tap[0] == HEADER_BYTE) && (psum[HIST_LEN] == s_rx_byte);

    always_comb begin
        result.frame_type = tap[1];
        result.word_a     = {tap[3], tap[2]};
        result.word_b     = {tap[5], tap[4]};
        result.word_c     = {tap[7], tap[6]};
        result.word_d     = {tap[9], tap[8]};
        result.known_type = type_is_known(tap[1]);
    end

    // Fill count: a good frame empties the window, a full window stays at ten.
    always_comb begin
        fill_next = fill_reg;
        if (s_accept) begin
            if (frame_ok) begin
                fill_next = '0;
            end else if (fill_reg != fill_t'(HIST_LEN)) begin
                fill_next = fill_reg + fill_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= frame_ok;
            end
        end else if (frame_ok) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else begin
                out_reg <= result;
            end
        end else if (frame_ok) begin
            skid_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_type = out_reg.frame_type;
    assign m_word_a     = out_reg.word_a;
    assign m_word_b     = out_reg.word_b;
    assign m_word_c     = out_reg.word_c;
    assign m_word_d     = out_reg.word_d;
    assign m_known_type = out_reg.known_type;

endmodule

### rtl/ifsc_checker.sv
// ----------------------------------------------------------------------------
// ifsc_checker: port-level checks of the frame parser
// Watches the top level's ports and reports violations; bound to the top.
// ----------------------------------------------------------------------------
module ifsc_checker
    import ifsc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_frame_type,
    input logic [15:0] m_word_a,
    input logic        m_known_type
);

    // A pending result is held until the receiver takes it.
    property p_result_holds;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && !m_ready |=> m_valid && $stable(m_frame_type) && $stable(m_word_a);
    endproperty
    a_result_holds: assert property (p_result_holds)
        else $error("result changed or dropped while stalled");

    // The flag must match the decoded type ranges.
    property p_known_flag;
        @(posedge aclk) disable iff (!aresetn)
            m_valid |-> (m_known_type == type_is_known(m_frame_type));
    endproperty
    a_known_flag: assert property (p_known_flag)
        else $error("known_type flag disagrees with frame_type");

    // Input back-pressure only happens with a result waiting.
    property p_stall_reason;
        @(posedge aclk) disable iff (!aresetn)
            !s_ready |-> m_valid;
    endproperty
    a_stall_reason: assert property (p_stall_reason)
        else $error("input stalled with no result pending");

    // A new result only appears right after a byte transaction.
    property p_result_source;
        @(posedge aclk) disable iff (!aresetn)
            $rose(m_valid) |-> $past(s_valid && s_ready);
    endproperty
    a_result_source: assert property (p_result_source)
        else $error("result appeared without a received byte");

endmodule

bind imu_frame_sync_checksum_parser_top ifsc_checker u_ifsc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_type (m_frame_type),
    .m_word_a     (m_word_a),
    .m_known_type (m_known_type)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for imu_frame_sync_checksum_parser_top
// Streams received bytes into the parser: directed frames first, then a long
// random stream of well-formed frames with random content, corrupted
// checksums, cut-off frames and loose noise bytes. A byte-level tracker of
// the sync window predicts every parsed frame, and each m_ transaction is
// compared field by field with the oldest prediction. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb
    import ifsc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Payload patterns for generated frames.
    typedef enum int {
        PAYLOAD_RANDOM,
        PAYLOAD_ZERO_ONES,
        PAYLOAD_ALL_ONES
    } payload_style_t;

    localparam int RANDOM_BYTES = 1700;
    localparam int DRAIN_EVERY  = 400;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_frame_type;
    logic [15:0] m_word_a;
    logic [15:0] m_word_b;
    logic [15:0] m_word_c;
    logic [15:0] m_word_d;
    logic        m_known_type;

    // Mirror of the sync window and the frames it is expected to yield.
    logic [7:0]   rx_window [FRAME_LEN];
    int           rx_fill = 0;
    ifsc_result_t pending_frames [$];

    int mismatch_count = 0;
    int bytes_sent = 0;
    bit sender_steady = 1'b0;

    imu_frame_sync_checksum_parser_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_type (m_frame_type),
        .m_word_a     (m_word_a),
        .m_word_b     (m_word_b),
        .m_word_c     (m_word_c),
        .m_word_d     (m_word_d),
        .m_known_type (m_known_type)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Types 0x50 to 0x5A are decoded, except the header value in the middle.
    function automatic logic decoded_kind(input logic [7:0] kind);
        return ((kind >= 8'h50) && (kind <= 8'h54)) || ((kind >= 8'h56) && (kind <= 8'h5A));
    endfunction

    // Mostly short idle gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the window mirror by one accepted byte.
    task automatic track_stream_byte(input logic [7:0] b);
        logic [7:0]   sum;
        ifsc_result_t frame;
        rx_window[rx_fill] = b;
        rx_fill++;
        if (rx_fill == FRAME_LEN) begin
            sum = 8'h00;
            for (int i = 0; i < FRAME_LEN - 1; i++) sum += rx_window[i];
            if (rx_window[0] == HEADER_BYTE && sum == rx_window[FRAME_LEN-1]) begin
                frame.frame_type = rx_window[1];
                frame.word_a     = {rx_window[3], rx_window[2]};
                frame.word_b     = {rx_window[5], rx_window[4]};
                frame.word_c     = {rx_window[7], rx_window[6]};
                frame.word_d     = {rx_window[9], rx_window[8]};
                frame.known_type = decoded_kind(rx_window[1]);
                pending_frames.push_back(frame);
                rx_fill = 0;
            end else begin
                // Drop the oldest byte and keep searching.
                for (int i = 0; i < FRAME_LEN - 1; i++) rx_window[i] = rx_window[i+1];
                rx_fill = FRAME_LEN - 1;
            end
        end
    endtask

    // Offer one byte and hold it until the parser takes it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = sender_steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_stream_byte(b);
        bytes_sent++;
    endtask

    // Build a frame with a valid or a broken checksum and send its first bytes.
    task automatic send_frame(input logic [7:0] kind, input bit break_sum,
                              input int unsigned keep, input payload_style_t style);
        logic [7:0] frame [FRAME_LEN];
        logic [7:0] sum;
        frame[0] = HEADER_BYTE;
        frame[1] = kind;
        for (int i = 2; i < FRAME_LEN - 1; i++) begin
            case (style)
                PAYLOAD_ZERO_ONES: begin
                    frame[i] = i[0] ? 8'hFF : 8'h00;
                end
                PAYLOAD_ALL_ONES: begin
                    frame[i] = 8'hFF;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0: frame[i] = 8'h00;
                        1: frame[i] = 8'hFF;
                        default: frame[i] = 8'($urandom_range(0, 255));
                    endcase
                end
            endcase
        end
        sum = 8'h00;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame[i];
        frame[FRAME_LEN-1] = break_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < keep; i++) send_byte(frame[i]);
    endtask

    // Mostly types around the decoded range, sometimes the header value or anything.
    function automatic logic [7:0] pick_kind();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'($urandom_range(8'h4E, 8'h5C));
        if (r == 5) return HEADER_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Stray bytes, often a false header.
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 3) == 0) return HEADER_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Stop sending and let every predicted frame come out.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Good frames at both ends of the decoded range and just outside it,
    // with extreme payloads.
    task automatic test_known_and_unknown_types();
        send_frame(KNOWN_LO, 1'b0, FRAME_LEN, PAYLOAD_ZERO_ONES);
        send_frame(KNOWN_HI, 1'b0, FRAME_LEN, PAYLOAD_ALL_ONES);
        send_frame(KNOWN_LO - 8'd1, 1'b0, FRAME_LEN, PAYLOAD_ALL_ONES);
        send_frame(KNOWN_HI + 8'd1, 1'b0, FRAME_LEN, PAYLOAD_ZERO_ONES);
        wait_for_results();
    endtask

    // A bad header, a frame typed with the header value, and a bad checksum.
    task automatic test_header_and_checksum_errors();
        send_byte(8'h00);
        send_frame(HEADER_BYTE, 1'b0, FRAME_LEN, PAYLOAD_ALL_ONES);
        send_frame(KNOWN_HI, 1'b1, FRAME_LEN, PAYLOAD_ZERO_ONES);
        wait_for_results();
    endtask

    // Long random stream; the sender pauses now and then until all results are out.
    task automatic test_random_stream();
        int          start_count;
        int          next_drain;
        int unsigned r;
        start_count = bytes_sent;
        next_drain  = bytes_sent + DRAIN_EVERY;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            sender_steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 75) begin
                send_frame(pick_kind(), 1'b0, FRAME_LEN, PAYLOAD_RANDOM);
            end else if (r < 85) begin
                send_frame(pick_kind(), 1'b1, FRAME_LEN, PAYLOAD_RANDOM);
            end else if (r < 92) begin
                send_frame(pick_kind(), 1'b0, $urandom_range(1, FRAME_LEN - 1),
                           PAYLOAD_RANDOM);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            end
            if (bytes_sent >= next_drain) begin
                wait_for_results();
                next_drain += DRAIN_EVERY;
            end
        end
        sender_steady = 1'b0;
        wait_for_results();
    endtask

    // Receiver stalls at random, with stretches of steady acceptance.
    initial begin : result_backpressure
        int unsigned hold;
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end else begin
                hold = idle_gap();
                if (hold > 0) begin
                    m_ready <= 1'b0;
                    repeat (hold) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare each result transaction with the oldest predicted frame.
    always @(posedge aclk) begin : result_check
        ifsc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual type %h",
                         $time, m_frame_type);
            end else begin
                want = pending_frames.pop_front();
                check_field("frame_type", 16'(want.frame_type), 16'(m_frame_type));
                check_field("word_a", want.word_a, m_word_a);
                check_field("word_b", want.word_b, m_word_b);
                check_field("word_c", want.word_c, m_word_c);
                check_field("word_d", want.word_d, m_word_d);
                check_field("known_type", 16'(want.known_type), 16'(m_known_type));
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_known_and_unknown_types();
        test_header_and_checksum_errors();
        test_random_stream();
        if (mismatch_count == 0 && pending_frames.size() == 0) begin
            $display("** imu_frame_sync_checksum_parser_top: PASSED **");
        end else begin
            $display("** imu_frame_sync_checksum_parser_top: FAILED **");
        end
        $finish;
    end

    // Run limit well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("** imu_frame_sync_checksum_parser_top: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/ifsc_pkg.sv
rtl/ifsc_cell.sv
rtl/imu_frame_sync_checksum_parser_top.sv
rtl/ifsc_checker.sv
tb/tb.sv
